// File: rtl/prt_pkg.sv
// ============================================================================
// prt_pkg - shared types and constants of the priority route table
// Table geometry, route entry layout, status codes and small helpers.
// ============================================================================
`default_nettype none

package prt_pkg;

	// Table geometry
	localparam int TABLE_DEPTH     = 16;
	localparam int INTERFACE_COUNT = 16;
	localparam int IDX_W           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);
	localparam int OUT_IDX_W       = 4;
	localparam int IFC_W           = 4;

	// Result status codes
	typedef enum logic [2:0] {
		STATUS_ADDED   = 3'd0,
		STATUS_UPDATED = 3'd1,
		STATUS_FULL    = 3'd2,
		STATUS_HIT     = 3'd3,
		STATUS_MISS    = 3'd4
	} status_t;

	// Command codes
	typedef enum logic {
		CMD_ADD    = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	// Control sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// One stored route
	typedef struct packed {
		logic [31:0]      network;
		logic [31:0]      mask;
		logic [IFC_W-1:0] ifc;
		logic [1:0]       link_type;
		logic             gw_valid;
		logic [31:0]      gateway;
		logic [7:0]       priority_val;
	} entry_t;

	// Write port request of the route memory
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	// Read port request of the route memory
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} mem_rd_t;

	// Interface number folded into the configured interface range (constant table)
	function automatic logic [IFC_W-1:0] ifc_wrap(input logic [IFC_W-1:0] val);
		logic [IFC_W-1:0] r;
		r = '0;
		for (int j = 0; j < (1 << IFC_W); j++) begin
			if (val == IFC_W'(j)) begin
				r = IFC_W'(j % INTERFACE_COUNT);
			end
		end
		return r;
	endfunction

	// Low bits of a table index as reported on the result port
	function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] idx);
		logic [IDX_W+OUT_IDX_W-1:0] tmp;
		tmp = {{OUT_IDX_W{1'b0}}, idx};
		return tmp[OUT_IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/prt_route_mem.sv
// ============================================================================
// prt_route_mem - route entry storage
// Single write port, single read port, read data registered.
// ============================================================================
`default_nettype none

module prt_route_mem (
	input  wire logic             clk,
	input  wire prt_pkg::mem_wr_t wr,
	input  wire prt_pkg::mem_rd_t rd,
	output prt_pkg::entry_t       rd_data
);

	prt_pkg::entry_t mem_q [prt_pkg::TABLE_DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem_q[rd.addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/priority_route_table_core.sv
// ============================================================================
// priority_route_table_core - IPv4 route table add / highest-priority lookup
// Stores routes in a single-port-read memory; every command scans the
// stored entries one per cycle, then writes back on an add and reports one result.
// ============================================================================
//
// Channel   | Handshake        | Payload
// ----------+------------------+---------------------------------------------
// command   | start / busy     | command, address, netmask, interface_id,
//           |                  | link_type, link_filter, gateway_valid,
//           |                  | gateway_address, priority_req
// result    | done (strobe)    | status, entry_index, out_interface,
//           |                  | out_gateway_valid, out_gateway, out_priority
//
// A transaction is taken when start is high and busy is low. The sequencer
// reads the N stored entries in ST_SCAN, then passes through ST_FINISH;
// done is registered from ST_FINISH and busy drops in that same cycle, so
// the next transaction can be taken while done is high. The scan length is
// set by the memory read port, which delivers one stored entry per cycle to
// the compare logic.
// Reset clears the entry count and control; memory contents need no clear.
// The done strobe is high for one cycle only; the receiver cannot stall it.
// ============================================================================
`default_nettype none

module priority_route_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        command,
	input  wire logic [31:0] address,
	input  wire logic [31:0] netmask,
	input  wire logic [3:0]  interface_id,
	input  wire logic [1:0]  link_type,
	input  wire logic        link_filter,
	input  wire logic        gateway_valid,
	input  wire logic [31:0] gateway_address,
	input  wire logic [7:0]  priority_req,
	output logic             done,
	output logic [2:0]       status,
	output logic [3:0]       entry_index,
	output logic [3:0]       out_interface,
	output logic             out_gateway_valid,
	output logic [31:0]      out_gateway,
	output logic [7:0]       out_priority
);

	// ------------------------------------------------------------------
	// Declarations
	// ------------------------------------------------------------------
	prt_pkg::state_t                 state_q, state_d;
	logic [prt_pkg::CNT_W-1:0]       entry_count_q;
	logic [prt_pkg::CNT_W-1:0]       issue_q;
	logic                            accept;

	// captured transaction
	prt_pkg::cmd_t                   cmd_q;
	logic [31:0]                     addr_q;
	logic [31:0]                     mask_q;
	logic [prt_pkg::IFC_W-1:0]       ifc_q;
	logic [1:0]                      lt_q;
	logic                            filt_q;
	logic                            gv_q;
	logic [31:0]                     gw_q;
	logic [7:0]                      pri_q;

	// read pipeline
	prt_pkg::mem_rd_t                rd;
	prt_pkg::mem_wr_t                wr;
	prt_pkg::entry_t                 rd_data;
	logic                            rd_vld_s1;
	logic [prt_pkg::IDX_W-1:0]       rd_idx_s1;

	// scan results
	logic                            found_q;
	logic [prt_pkg::IDX_W-1:0]       best_idx_q;
	prt_pkg::entry_t                 best_q;
	logic                            add_match;
	logic                            lkp_pass;
	logic                            take;
	logic                            table_full;
	prt_pkg::entry_t                 new_entry;
	prt_pkg::entry_t                 upd_entry;

	// result registers
	logic                            done_q;
	prt_pkg::status_t                status_q;
	logic [3:0]                      index_q;
	logic [3:0]                      ifc_out_q;
	logic                            gv_out_q;
	logic [31:0]                     gw_out_q;
	logic [7:0]                      pri_out_q;

	assign accept = start && !busy;

	// ------------------------------------------------------------------
	// Route memory
	// ------------------------------------------------------------------
	prt_route_mem u_mem (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	// ------------------------------------------------------------------
	// Compare of the entry coming out of memory
	// ------------------------------------------------------------------
	assign add_match = (rd_data.network == addr_q) && (rd_data.mask == mask_q) &&
		(rd_data.ifc == ifc_q);
	assign lkp_pass  = (!filt_q || (rd_data.link_type == lt_q)) &&
		((addr_q & rd_data.mask) == (rd_data.network & rd_data.mask));
	always_comb begin
		if (cmd_q == prt_pkg::CMD_ADD) begin
			take = rd_vld_s1 && add_match && !found_q;
		end else begin
			take = rd_vld_s1 && lkp_pass &&
				(!found_q || (rd_data.priority_val > best_q.priority_val));
		end
	end

	assign table_full = (entry_count_q == prt_pkg::CNT_W'(prt_pkg::TABLE_DEPTH));

	// Entries written back at the end of an add
	always_comb begin
		new_entry.network      = addr_q;
		new_entry.mask         = mask_q;
		new_entry.ifc          = ifc_q;
		new_entry.link_type    = lt_q;
		new_entry.gw_valid     = gv_q;
		new_entry.gateway      = gw_q;
		new_entry.priority_val = pri_q;
		upd_entry              = best_q;
		upd_entry.gw_valid     = gv_q;
		upd_entry.gateway      = gw_q;
	end

	// ------------------------------------------------------------------
	// Sequencer: next state and memory requests
	// ------------------------------------------------------------------
	always_comb begin
		state_d  = state_q;
		rd.en    = 1'b0;
		rd.addr  = issue_q[prt_pkg::IDX_W-1:0];
		wr.en    = 1'b0;
		wr.addr  = best_idx_q;
		wr.data  = upd_entry;
		busy     = (state_q != prt_pkg::ST_IDLE);
		case (state_q)
			prt_pkg::ST_IDLE: begin
				if (start) begin
					state_d = prt_pkg::ST_SCAN;
				end
			end
			prt_pkg::ST_SCAN: begin
				rd.en = (issue_q < entry_count_q);
				if (!rd.en && !rd_vld_s1) begin
					state_d = prt_pkg::ST_FINISH;
				end
			end
			prt_pkg::ST_FINISH: begin
				if (cmd_q == prt_pkg::CMD_ADD) begin
					if (found_q) begin
						wr.en = 1'b1;
					end else if (!table_full) begin
						wr.en   = 1'b1;
						wr.addr = entry_count_q[prt_pkg::IDX_W-1:0];
						wr.data = new_entry;
					end
				end
				state_d = prt_pkg::ST_IDLE;
			end
			default: begin
				state_d = prt_pkg::ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= prt_pkg::ST_IDLE;
			entry_count_q <= '0;
			issue_q       <= '0;
			rd_vld_s1     <= 1'b0;
			found_q       <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd.en;
			done_q    <= (state_q == prt_pkg::ST_FINISH);
			if (accept) begin
				issue_q <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd.en) begin
					issue_q <= issue_q + prt_pkg::CNT_W'(1);
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			// append grows the table
			if ((state_q == prt_pkg::ST_FINISH) && (cmd_q == prt_pkg::CMD_ADD) &&
				!found_q && !table_full) begin
				entry_count_q <= entry_count_q + prt_pkg::CNT_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Transaction capture and scan bookkeeping
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd.addr;
		if (accept) begin
			cmd_q  <= prt_pkg::cmd_t'(command);
			addr_q <= address;
			mask_q <= netmask;
			ifc_q  <= prt_pkg::ifc_wrap(interface_id);
			lt_q   <= link_type;
			filt_q <= link_filter;
			gv_q   <= gateway_valid;
			gw_q   <= gateway_address;
			pri_q  <= priority_req;
		end
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rd_data;
		end
	end

	// ------------------------------------------------------------------
	// Result formation
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == prt_pkg::ST_FINISH) begin
			index_q   <= '0;
			ifc_out_q <= '0;
			gv_out_q  <= 1'b0;
			gw_out_q  <= '0;
			pri_out_q <= '0;
			if (cmd_q == prt_pkg::CMD_ADD) begin
				if (found_q) begin
					status_q <= prt_pkg::STATUS_UPDATED;
					index_q  <= prt_pkg::out_index(best_idx_q);
				end else if (table_full) begin
					status_q <= prt_pkg::STATUS_FULL;
				end else begin
					status_q <= prt_pkg::STATUS_ADDED;
					index_q  <= prt_pkg::out_index(entry_count_q[prt_pkg::IDX_W-1:0]);
				end
			end else if (found_q) begin
				status_q  <= prt_pkg::STATUS_HIT;
				index_q   <= prt_pkg::out_index(best_idx_q);
				ifc_out_q <= best_q.ifc;
				gv_out_q  <= best_q.gw_valid;
				gw_out_q  <= best_q.gateway;
				pri_out_q <= best_q.priority_val;
			end else begin
				status_q <= prt_pkg::STATUS_MISS;
			end
		end
	end

	assign done              = done_q;
	assign status            = status_q;
	assign entry_index       = index_q;
	assign out_interface     = ifc_out_q;
	assign out_gateway_valid = gv_out_q;
	assign out_gateway       = gw_out_q;
	assign out_priority      = pri_out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == prt_pkg::ST_FINISH))
		else $error("result strobe without a finish cycle");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= prt_pkg::CNT_W'(prt_pkg::TABLE_DEPTH))
		else $error("entry count above table depth");

	a_write_in_finish: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == prt_pkg::ST_FINISH))
		else $error("memory write outside finish cycle");

	a_busy_drop_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

endmodule

`default_nettype wire
